[rtl/ifd_directory_entry_writer_macros.svh]
// assertion macros shared by the directory entry writer rtl
`ifndef IFD_DIRECTORY_ENTRY_WRITER_MACROS_SVH
`define IFD_DIRECTORY_ENTRY_WRITER_MACROS_SVH

`ifndef SYNTHESIS

`define IFDW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define IFDW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define IFDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IFDW_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`define IFDW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define IFDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/ifdw_pkg.sv]
// types and constants of the directory entry writer
`timescale 1ns / 1ps
`default_nettype none

package ifdw_pkg;

    typedef enum logic {
        ITEM_BEGIN = 1'b0,
        ITEM_TAG   = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        REC_HEADER  = 2'd0,
        REC_ENTRY   = 2'd1,
        REC_TRAILER = 2'd2
    } record_kind_t;

    // tiff type codes that do not use two-byte units
    localparam logic [15:0] TYPE_BYTE      = 16'd1;
    localparam logic [15:0] TYPE_ASCII     = 16'd2;
    localparam logic [15:0] TYPE_LONG      = 16'd4;
    localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
    localparam logic [15:0] TYPE_UNDEFINED = 16'd7;
    localparam logic [15:0] TYPE_SLONG     = 16'd9;
    localparam logic [15:0] TYPE_SRATIONAL = 16'd10;

    localparam logic [31:0] ENTRY_BYTES    = 32'd12;
    localparam logic [31:0] FWD_START_ADJ  = 32'd6;
    localparam logic [31:0] INLINE_MAX     = 32'd4;

    typedef struct packed {
        item_kind_t   kind;
        logic [15:0]  tag_count;
        logic [31:0]  base_position;
        logic [15:0]  tag_id;
        logic [15:0]  data_type;
        logic [31:0]  value_count;
        logic [31:0]  inline_value;
        logic         last_entry;
    } item_t;

    typedef struct packed {
        record_kind_t kind;
        logic [15:0]  tag;
        logic [15:0]  data_type;
        logic [31:0]  count;
        logic [31:0]  value;
        logic         out_of_line;
        logic [31:0]  payload_bytes;
        logic [31:0]  end_position;
        logic         last;
    } result_t;

endpackage

`default_nettype wire

[rtl/ifdw_entry_calc.sv]
// formats the records of one directory item and the next forward position
`timescale 1ns / 1ps
`default_nettype none

module ifdw_entry_calc (
    input  ifdw_pkg::item_t   item,
    input  logic [31:0]       fwd_pos,
    input  logic [31:0]       next_ifd_offset,
    output ifdw_pkg::result_t rec0,
    output ifdw_pkg::result_t rec1,
    output logic              two_results,
    output logic [31:0]       fwd_pos_next
);
    import ifdw_pkg::*;

    logic [1:0]  unit_shift;
    logic [31:0] length;
    logic        is_inline;
    logic [31:0] masked_value;
    logic [31:0] padded_len;
    logic [31:0] tag_fwd_next;
    logic [31:0] begin_fwd;

    // log2 of the unit size of the type
    always_comb
    begin
        case (item.data_type) inside
            TYPE_BYTE, TYPE_ASCII, TYPE_UNDEFINED: unit_shift = 2'd0;
            TYPE_LONG, TYPE_SLONG:                 unit_shift = 2'd2;
            TYPE_RATIONAL, TYPE_SRATIONAL:         unit_shift = 2'd3;
            default:                               unit_shift = 2'd1;
        endcase
    end

    assign length     = item.value_count << unit_shift;
    assign is_inline  = (length <= INLINE_MAX);
    assign padded_len = length + {31'd0, length[0]};
    assign tag_fwd_next = is_inline ? fwd_pos : fwd_pos + padded_len;
    assign begin_fwd  = 32'(item.tag_count) * ENTRY_BYTES + item.base_position
                        - FWD_START_ADJ;

    // zero length keeps one byte, like length one
    always_comb
    begin
        case (length[2:0])
            3'd4:    masked_value = item.inline_value;
            3'd3:    masked_value = {8'd0, item.inline_value[23:0]};
            3'd2:    masked_value = {16'd0, item.inline_value[15:0]};
            default: masked_value = {24'd0, item.inline_value[7:0]};
        endcase
    end

    always_comb
    begin
        rec0 = '0;
        rec1 = '0;
        two_results  = 1'b0;
        fwd_pos_next = fwd_pos;
        rec1.kind         = REC_TRAILER;
        rec1.value        = next_ifd_offset;
        rec1.end_position = tag_fwd_next + ENTRY_BYTES;
        rec1.last         = 1'b1;
        case (item.kind)
            ITEM_BEGIN:
            begin
                rec0.kind    = REC_HEADER;
                rec0.value   = 32'(item.tag_count);
                rec0.last    = 1'b1;
                fwd_pos_next = begin_fwd;
            end
            ITEM_TAG:
            begin
                rec0.kind          = REC_ENTRY;
                rec0.tag           = item.tag_id;
                rec0.data_type     = item.data_type;
                rec0.count         = item.value_count;
                rec0.value         = is_inline ? masked_value : fwd_pos;
                rec0.out_of_line   = !is_inline;
                rec0.payload_bytes = is_inline ? 32'd0 : padded_len;
                rec0.last          = !item.last_entry;
                two_results        = item.last_entry;
                fwd_pos_next       = tag_fwd_next;
            end
            default:
            begin
                rec0.kind = REC_HEADER;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/ifdw_result_fifo.sv]
// result queue that takes one or two records a cycle and drains one
`timescale 1ns / 1ps
`default_nettype none

`include "ifd_directory_entry_writer_macros.svh"

module ifdw_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push0,
    input  logic              push1,
    input  ifdw_pkg::result_t rec0,
    input  ifdw_pkg::result_t rec1,
    input  logic              pop,
    output ifdw_pkg::result_t head,
    output logic              not_empty,
    output logic              room_for_two
);
    import ifdw_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_ptr_reg] <= rec0;
        end
        if (push1)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= CNT_W'(DEPTH - 2));

    `IFDW_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue overflow")
    `IFDW_ASSERT_IMPLY(a_second_needs_first, clk, rst_n, push1, push0, "second record pushed alone")
    `IFDW_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/ifd_directory_entry_writer.sv]
// top level of the tiff directory entry writer
`timescale 1ns / 1ps
`default_nettype none

`include "ifd_directory_entry_writer_macros.svh"

// Turns begin and tag beats into directory records: a header per begin, an
// entry per tag, and a trailer after the tag flagged last_entry. One input
// beat is taken per cycle while in_stall is low; its records pass through the
// input register and then the result queue. The rate is set by the output
// side, which delivers one record per cycle while out_stall is low from
// a four-record queue, so n tags give n + 2 records. in_stall rises while
// a beat waits in the input register and the queue has fewer than two free
// slots. The forward position register advances once per beat through a
// single add chain, so beats never wait on each other. next_ifd_offset may
// be written at any time the block is idle; cfg_ready is always high.
module ifd_directory_entry_writer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] next_ifd_offset,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] tag_count,
    input  logic [31:0] base_position,
    input  logic [15:0] tag_id,
    input  logic [15:0] data_type,
    input  logic [31:0] value_count,
    input  logic [31:0] inline_value,
    input  logic        last_entry,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_kind,
    output logic [15:0] entry_tag,
    output logic [15:0] entry_type,
    output logic [31:0] entry_count,
    output logic [31:0] value_field,
    output logic        out_of_line,
    output logic [31:0] payload_bytes,
    output logic [31:0] end_position,
    output logic        last_of_run
);
    import ifdw_pkg::*;

    item_t       item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic [31:0] fwd_pos_reg;
    logic [31:0] fwd_pos_next;
    logic [31:0] next_offset_reg;

    result_t     rec0;
    result_t     rec1;
    result_t     head;
    logic        two_results;
    logic        room_for_two;
    logic        advance;
    logic        in_accept;
    logic        pop;

    assign cfg_ready = 1'b1;

    assign advance         = item_valid_reg && room_for_two;
    assign in_stall        = item_valid_reg && !room_for_two;
    assign in_accept       = in_valid && !in_stall;
    assign item_valid_next = in_accept || (item_valid_reg && !advance);
    assign pop             = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.kind          <= item_kind_t'(kind);
            item_reg.tag_count     <= tag_count;
            item_reg.base_position <= base_position;
            item_reg.tag_id        <= tag_id;
            item_reg.data_type     <= data_type;
            item_reg.value_count   <= value_count;
            item_reg.inline_value  <= inline_value;
            item_reg.last_entry    <= last_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            fwd_pos_reg     <= '0;
            next_offset_reg <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (advance)
            begin
                fwd_pos_reg <= fwd_pos_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                next_offset_reg <= next_ifd_offset;
            end
        end
    end

    ifdw_entry_calc u_calc (
        .item            (item_reg),
        .fwd_pos         (fwd_pos_reg),
        .next_ifd_offset (next_offset_reg),
        .rec0            (rec0),
        .rec1            (rec1),
        .two_results     (two_results),
        .fwd_pos_next    (fwd_pos_next)
    );

    ifdw_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push0        (advance),
        .push1        (advance && two_results),
        .rec0         (rec0),
        .rec1         (rec1),
        .pop          (pop),
        .head         (head),
        .not_empty    (out_valid),
        .room_for_two (room_for_two)
    );

    assign record_kind   = head.kind;
    assign entry_tag     = head.tag;
    assign entry_type    = head.data_type;
    assign entry_count   = head.count;
    assign value_field   = head.value;
    assign out_of_line   = head.out_of_line;
    assign payload_bytes = head.payload_bytes;
    assign end_position  = head.end_position;
    assign last_of_run   = head.last;

    `IFDW_ASSERT_IMPLY(a_stall_needs_item, clk, rst_n, in_stall, item_valid_reg, "stall with empty input register")
    `IFDW_ASSERT_NEXT(a_fwd_held, clk, rst_n, !advance, $stable(fwd_pos_reg), "forward position moved without a beat")
    `IFDW_ASSERT_IMPLY(a_load_from_beat, clk, rst_n, $rose(item_valid_reg), $past(in_valid && !in_stall), "input register loaded without a beat")

endmodule

`default_nettype wire

[verif/tb.sv]
// self-checking testbench for the tiff directory entry writer
`timescale 1ns / 1ps

module tb;
    import ifdw_pkg::*;

    typedef enum logic [1:0] {
        ACT_ITEM   = 2'd0,
        ACT_CONFIG = 2'd1,
        ACT_DRAIN  = 2'd2
    } action_t;

    typedef struct packed {
        action_t     act;
        item_t       item;
        logic [31:0] cfg_data;
        logic [2:0]  gap;
    } stim_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [31:0] next_ifd_offset = '0;

    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic        kind          = 1'b0;
    logic [15:0] tag_count     = '0;
    logic [31:0] base_position = '0;
    logic [15:0] tag_id        = '0;
    logic [15:0] data_type     = '0;
    logic [31:0] value_count   = '0;
    logic [31:0] inline_value  = '0;
    logic        last_entry    = 1'b0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  record_kind;
    logic [15:0] entry_tag;
    logic [15:0] entry_type;
    logic [31:0] entry_count;
    logic [31:0] value_field;
    logic        out_of_line;
    logic [31:0] payload_bytes;
    logic [31:0] end_position;
    logic        last_of_run;

    // stimulus and expected records
    stim_t       pending[$];
    result_t     expected_records[$];

    // predictor state
    logic [31:0] fwd_pos;
    logic [31:0] trailer_offset;

    int          mismatches   = 0;
    int          records_seen = 0;
    int          item_total   = 0;
    bit          quiet_gaps   = 1'b0;

    // driver and monitor working variables
    item_t       offered;
    stim_t       head;
    logic        in_busy;
    logic        cfg_busy;
    logic        next_in_valid;
    logic        next_cfg_valid;
    int          gap_count;
    int          stall_left;
    result_t     seen;
    result_t     want;

    ifd_directory_entry_writer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .next_ifd_offset (next_ifd_offset),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .tag_count       (tag_count),
        .base_position   (base_position),
        .tag_id          (tag_id),
        .data_type       (data_type),
        .value_count     (value_count),
        .inline_value    (inline_value),
        .last_entry      (last_entry),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .record_kind     (record_kind),
        .entry_tag       (entry_tag),
        .entry_type      (entry_type),
        .entry_count     (entry_count),
        .value_field     (value_field),
        .out_of_line     (out_of_line),
        .payload_bytes   (payload_bytes),
        .end_position    (end_position),
        .last_of_run     (last_of_run)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] unit_bytes(input logic [15:0] code);
        case (code)
            TYPE_BYTE, TYPE_ASCII, TYPE_UNDEFINED: return 32'd1;
            TYPE_LONG, TYPE_SLONG:                 return 32'd4;
            TYPE_RATIONAL, TYPE_SRATIONAL:         return 32'd8;
            default:                               return 32'd2;
        endcase
    endfunction

    // expected records of one accepted beat, advancing the forward position
    function automatic void predict_records(input item_t it);
        result_t     r;
        logic [31:0] len;
        logic [31:0] pad_len;
        r = '0;
        if (it.kind == ITEM_BEGIN)
        begin
            fwd_pos = {16'd0, it.tag_count} * ENTRY_BYTES - FWD_START_ADJ + it.base_position;
            r.kind  = REC_HEADER;
            r.value = {16'd0, it.tag_count};
            r.last  = 1'b1;
            expected_records.push_back(r);
        end
        else
        begin
            len         = unit_bytes(it.data_type) * it.value_count;
            r.kind      = REC_ENTRY;
            r.tag       = it.tag_id;
            r.data_type = it.data_type;
            r.count     = it.value_count;
            if (len <= INLINE_MAX)
            begin
                case (len)
                    32'd4:   r.value = it.inline_value;
                    32'd3:   r.value = it.inline_value & 32'h00FF_FFFF;
                    32'd2:   r.value = it.inline_value & 32'h0000_FFFF;
                    default: r.value = it.inline_value & 32'h0000_00FF;
                endcase
            end
            else
            begin
                pad_len         = len + {31'd0, len[0]};
                r.value         = fwd_pos;
                r.out_of_line   = 1'b1;
                r.payload_bytes = pad_len;
                fwd_pos         = fwd_pos + pad_len;
            end
            r.last = !it.last_entry;
            expected_records.push_back(r);
            if (it.last_entry)
            begin
                r              = '0;
                r.kind         = REC_TRAILER;
                r.value        = trailer_offset;
                r.end_position = fwd_pos + ENTRY_BYTES;
                r.last         = 1'b1;
                expected_records.push_back(r);
            end
        end
    endfunction

    function automatic item_t make_begin(input logic [15:0] cnt, input logic [31:0] base);
        item_t it;
        it.kind          = ITEM_BEGIN;
        it.tag_count     = cnt;
        it.base_position = base;
        // fields the block ignores on a begin still get random content
        it.tag_id        = 16'($urandom());
        it.data_type     = 16'($urandom());
        it.value_count   = $urandom();
        it.inline_value  = $urandom();
        it.last_entry    = 1'($urandom());
        return it;
    endfunction

    function automatic item_t make_tag(input logic [15:0] id, input logic [15:0] code,
                                       input logic [31:0] cnt, input logic [31:0] val,
                                       input logic last);
        item_t it;
        it.kind          = ITEM_TAG;
        it.tag_count     = 16'($urandom());
        it.base_position = $urandom();
        it.tag_id        = id;
        it.data_type     = code;
        it.value_count   = cnt;
        it.inline_value  = val;
        it.last_entry    = last;
        return it;
    endfunction

    function automatic item_t rand_tag(input logic last);
        logic [15:0] code;
        logic [31:0] cnt;
        case ($urandom_range(0, 9))
            0:       code = TYPE_BYTE;
            1:       code = TYPE_ASCII;
            2:       code = TYPE_UNDEFINED;
            3:       code = TYPE_LONG;
            4:       code = TYPE_SLONG;
            5:       code = TYPE_RATIONAL;
            6:       code = TYPE_SRATIONAL;
            7:       code = 16'd3;
            default: code = 16'($urandom());
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cnt = $urandom_range(0, 6);
            6:                cnt = $urandom_range(0, 300);
            7:                cnt = $urandom();
            8:
                case ($urandom_range(0, 4))
                    0:       cnt = 32'hFFFF_FFFF;
                    1:       cnt = 32'h4000_0000;
                    2:       cnt = 32'h8000_0000;
                    3:       cnt = 32'h2000_0000;
                    default: cnt = 32'h3FFF_FFFF;
                endcase
            default:          cnt = $urandom_range(0, 2);
        endcase
        return make_tag(16'($urandom()), code, cnt, $urandom(), last);
    endfunction

    task automatic push_item(input item_t it);
        stim_t s;
        s          = '0;
        s.act      = ACT_ITEM;
        s.item     = it;
        s.gap      = quiet_gaps ? 3'd0 : 3'($urandom_range(0, 7));
        pending.push_back(s);
        item_total++;
    endtask

    task automatic push_cfg(input logic [31:0] data);
        stim_t s;
        s          = '0;
        s.act      = ACT_CONFIG;
        s.cfg_data = data;
        pending.push_back(s);
    endtask

    task automatic push_drain();
        stim_t s;
        s     = '0;
        s.act = ACT_DRAIN;
        pending.push_back(s);
    endtask

    // driver: one beat or one register write at a time, drawn from pending
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            cfg_valid      <= 1'b0;
            gap_count      = 0;
            fwd_pos        = '0;
            trailer_offset = '0;
        end
        else
        begin
            in_busy  = in_valid;
            cfg_busy = cfg_valid;
            if (in_valid && !in_stall)
            begin
                predict_records(offered);
                in_busy = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                trailer_offset = next_ifd_offset;
                cfg_busy       = 1'b0;
            end
            next_in_valid  = in_busy;
            next_cfg_valid = cfg_busy;
            if (!in_busy && !cfg_busy && pending.size() > 0)
            begin
                head = pending[0];
                case (head.act)
                    ACT_ITEM:
                        if (gap_count < head.gap)
                        begin
                            gap_count++;
                        end
                        else
                        begin
                            gap_count     = 0;
                            offered       = head.item;
                            kind          <= head.item.kind;
                            tag_count     <= head.item.tag_count;
                            base_position <= head.item.base_position;
                            tag_id        <= head.item.tag_id;
                            data_type     <= head.item.data_type;
                            value_count   <= head.item.value_count;
                            inline_value  <= head.item.inline_value;
                            last_entry    <= head.item.last_entry;
                            next_in_valid = 1'b1;
                            void'(pending.pop_front());
                        end
                    ACT_CONFIG:
                        // register writes only with nothing in flight
                        if (expected_records.size() == 0)
                        begin
                            next_ifd_offset <= head.cfg_data;
                            next_cfg_valid  = 1'b1;
                            void'(pending.pop_front());
                        end
                    default:
                        if (expected_records.size() == 0)
                            void'(pending.pop_front());
                endcase
            end
            in_valid  <= next_in_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // monitor: random stalls per record, compare against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen.kind          = record_kind_t'(record_kind);
                seen.tag           = entry_tag;
                seen.data_type     = entry_type;
                seen.count         = entry_count;
                seen.value         = value_field;
                seen.out_of_line   = out_of_line;
                seen.payload_bytes = payload_bytes;
                seen.end_position  = end_position;
                seen.last          = last_of_run;
                if (expected_records.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected record: kind %0d tag %h type %h count %h val %h",
                                 seen.kind, seen.tag, seen.data_type, seen.count, seen.value);
                end
                else
                begin
                    want = expected_records.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("record %0d mismatch", records_seen);
                            $display("  exp: kind %0d tag %h type %h count %h val %h",
                                     want.kind, want.tag, want.data_type, want.count,
                                     want.value);
                            $display("       ool %b pay %h end %h last %b",
                                     want.out_of_line, want.payload_bytes,
                                     want.end_position, want.last);
                            $display("  act: kind %0d tag %h type %h count %h val %h",
                                     seen.kind, seen.tag, seen.data_type, seen.count,
                                     seen.value);
                            $display("       ool %b pay %h end %h last %b",
                                     seen.out_of_line, seen.payload_bytes,
                                     seen.end_position, seen.last);
                        end
                    end
                end
                records_seen++;
                // every third stretch of 60 records runs without stalls
                if ((records_seen / 60) % 3 == 1)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 7);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int          n;
        int          early;
        int          sel;
        logic [31:0] base;

        // directed part
        push_cfg(32'hFFFF_FFFF);
        push_item(make_tag(16'h0100, TYPE_LONG, 32'd3, 32'h1234_5678, 1'b0));
        push_item(make_begin(16'd0, 32'h0000_0010));
        push_item(make_tag(16'h0000, TYPE_BYTE, 32'd0, 32'hFFFF_FFFF, 1'b0));
        push_item(make_tag(16'h0101, TYPE_ASCII, 32'd3, 32'hFFFF_FFFF, 1'b0));
        push_item(make_tag(16'h0102, TYPE_UNDEFINED, 32'd5, 32'hA5A5_A5A5, 1'b0));
        push_item(make_tag(16'h0103, 16'd3, 32'd2, 32'hDEAD_BEEF, 1'b0));
        push_item(make_tag(16'h0104, TYPE_SLONG, 32'd1, 32'hFFFF_FFFF, 1'b0));
        push_item(make_tag(16'h0105, TYPE_RATIONAL, 32'd1, 32'h0000_0001, 1'b0));
        push_item(make_tag(16'h0106, TYPE_SRATIONAL, 32'd2, 32'h8000_0000, 1'b0));
        push_item(make_tag(16'h0107, 16'd0, 32'd1, 32'hFFFF_FFFF, 1'b0));
        push_item(make_tag(16'h0108, 16'hFFFF, 32'd3, 32'h0F0F_0F0F, 1'b0));
        // odd all-ones length pads to zero and leaves the position alone
        push_item(make_tag(16'h0109, TYPE_BYTE, 32'hFFFF_FFFF, 32'h1111_1111, 1'b0));
        push_item(make_tag(16'h010A, TYPE_LONG, 32'h4000_0000, 32'hFFFF_FFFF, 1'b0));
        push_item(make_tag(16'hFFFF, 16'd8, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
        push_item(make_tag(16'h010B, TYPE_RATIONAL, 32'h2000_0000, 32'h7777_7777, 1'b0));
        push_item(make_tag(16'h010C, 16'd11, 32'h7FFF_FFFF, 32'h0, 1'b1));
        push_item(make_begin(16'hFFFF, 32'hFFFF_FFFF));
        push_item(make_tag(16'h010D, 16'd6, 32'd1, 32'hFFFF_FFFF, 1'b1));
        push_drain();
        push_cfg(32'h0000_0000);
        push_item(make_begin(16'd1, 32'h0000_0000));
        push_item(make_tag(16'h0000, 16'd0, 32'd0, 32'h0, 1'b1));

        // random directories, register rewritten between phases
        item_total = 0;
        while (item_total < 1000)
        begin
            quiet_gaps = ((item_total / 40) % 4 == 1);
            if (item_total % 150 < 6 && $urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_cfg(32'h0000_0000);
                    1:       push_cfg(32'hFFFF_FFFF);
                    default: push_cfg($urandom());
                endcase
            end
            if ($urandom_range(0, 30) == 0)
                push_drain();
            sel  = $urandom_range(0, 99);
            base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))
                                               : $urandom();
            if (sel < 80)
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40)
                                                 : $urandom_range(1, 6);
                push_item(make_begin(16'(n), base));
                for (int i = 0; i < n; i++)
                    push_item(rand_tag(i == n - 1));
            end
            else if (sel < 90)
            begin
                // broken directory: last flag early, late or missing
                n     = $urandom_range(1, 8);
                early = $urandom_range(0, n);
                push_item(make_begin(16'($urandom()), base));
                for (int i = 0; i < n; i++)
                    push_item(rand_tag(i == early));
            end
            else
            begin
                push_item(rand_tag(1'($urandom())));
            end
        end
        push_drain();
        push_cfg($urandom());
        push_item(make_begin(16'd2, $urandom()));
        push_item(rand_tag(1'b0));
        push_item(rand_tag(1'b1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || in_valid || cfg_valid || expected_records.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
